// ----- hw/rtl/bwt_pkg.sv -----
// Package with the payload types, codes and sizes of the BWT rotation sorter.
package bwt_pkg;

    // Store depth, the widths that follow from it, and the symbol width.
    localparam int MAX_LEN = 1024;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = AW + 1;
    localparam int SW      = 17;

    localparam logic [SW-1:0] SEP_RESET = 17'd99999;

    // Function codes of an input transaction.
    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_BUILD  = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;

    // Error codes of a result transaction.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]    func;
        logic [SW-1:0] symbol;
        logic [9:0]    rank;
    } t_in;

    typedef struct packed {
        logic [SW-1:0] bwt_symbol;
        logic [9:0]    rotation_start;
        logic [10:0]   text_length;
        logic [10:0]   sequence_count;
        logic [1:0]    error;
    } t_out;

endpackage

// ----- hw/rtl/bwt_rotation_sort_core.sv -----
// Top level of the BWT rotation sorter: text store, merge sort sequencer and query path.
// Append, func 3 and refused queries give their result in the cycle after acceptance; a query
// passes S_QRY_RD, S_QRY_TXT, S_QRY_OUT (order memory read, then text memory read). Build:
// seeds the order in S_INIT, then over ceil(log2(n)) passes merges each segment (S_SEG), using
// S_MRD, S_MSEL per merge step and S_CRD, S_CCHK per symbol compared. A new transaction is
// accepted the cycle after the result is taken; reset clears counts and flags, sets SEP_RESET.
module bwt_rotation_sort_core
    import bwt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [SW-1:0] i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in           i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out          o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_QRY_RD, S_QRY_TXT, S_QRY_OUT, S_INIT, S_SEG, S_MRD, S_MSEL, S_CRD, S_CCHK
    } t_state;

    typedef enum logic [1:0] {M_CMP, M_CPX, M_CPY} t_mode;

    t_state        r_state;
    t_mode         r_mode;
    logic [SW-1:0] r_sep;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_seq;
    logic          r_built;
    logic          r_sel;
    logic [11:0]   r_width;
    logic [11:0]   r_lo;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [CW-1:0] r_o;
    logic [CW-1:0] r_k;
    logic [AW-1:0] r_pa;
    logic [AW-1:0] r_pb;
    logic [AW-1:0] r_ax;
    logic [AW-1:0] r_ay;
    logic [AW-1:0] r_start;
    logic          r_out_valid;
    t_out          r_out;

    // Memories and their registered read data.
    logic [SW-1:0] r_text_mem [MAX_LEN];
    logic [AW-1:0] r_ord_a [MAX_LEN];
    logic [AW-1:0] r_ord_b [MAX_LEN];
    logic [SW-1:0] r_t0, r_t1;
    logic [AW-1:0] r_a0, r_a1, r_b0, r_b1;

    logic          accept;
    logic [AW-1:0] ord_ra0, ord_ra1;
    logic [AW-1:0] txt_ra0, txt_ra1;
    logic [AW-1:0] src0, src1;
    logic [CW-1:0] n_len_m1;
    logic          ord_we_a, ord_we_b, mrg_we;
    logic [AW-1:0] ord_wa, ord_wd;
    logic          less;
    logic [11:0]   lo_w, mid_w, hi_w, lo_next, width_next;
    logic [CW-1:0] pa_inc, pb_inc;

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE) && !r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign n_len_m1 = r_len - CW'(1);

    // Read addresses: the query rank while idle, else the merge cursors.
    assign ord_ra0 = (r_state == S_IDLE) ? i_in.rank[AW-1:0] : r_x[AW-1:0];
    assign ord_ra1 = r_y[AW-1:0];
    assign txt_ra0 = AW'(n_len_m1 - CW'(r_pa));
    assign txt_ra1 = AW'(n_len_m1 - CW'(r_pb));

    assign src0 = r_sel ? r_b0 : r_a0;
    assign src1 = r_sel ? r_b1 : r_a1;

    // Merge segment bounds.
    assign lo_w       = r_lo + r_width;
    assign mid_w      = (lo_w < 12'(r_len)) ? lo_w : 12'(r_len);
    assign hi_w       = ((mid_w + r_width) < 12'(r_len)) ? (mid_w + r_width) : 12'(r_len);
    assign lo_next    = r_lo + (r_width << 1);
    assign width_next = r_width << 1;

    // Rotation position step with wraparound.
    assign pa_inc = (CW'(r_pa) + CW'(1) == r_len) ? '0 : CW'(r_pa) + CW'(1);
    assign pb_inc = (CW'(r_pb) + CW'(1) == r_len) ? '0 : CW'(r_pb) + CW'(1);

    // Outcome of one merge step and the order memory write.
    always_comb begin
        less   = 1'b0;
        mrg_we = 1'b0;
        if (r_state == S_MSEL) begin
            mrg_we = (r_mode != M_CMP);
        end else if (r_state == S_CCHK) begin
            if (r_t0 != r_t1) begin
                less   = r_t0 < r_t1;
                mrg_we = 1'b1;
            end else if (r_k + CW'(1) == r_len) begin
                less   = r_ay < r_ax;
                mrg_we = 1'b1;
            end
        end
    end

    always_comb begin
        ord_wa = r_o[AW-1:0];
        ord_wd = less ? r_ay : r_ax;
        if (r_state == S_INIT) begin
            ord_wa = r_x[AW-1:0];
            ord_wd = r_x[AW-1:0];
        end else if (r_state == S_MSEL) begin
            ord_wd = (r_mode == M_CPX) ? src0 : src1;
        end
    end

    assign ord_we_a = (r_state == S_INIT) || (mrg_we && r_sel);
    assign ord_we_b = mrg_we && !r_sel;

    // Text memory: append write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (accept && i_in.func == FN_APPEND && r_len < CW'(MAX_LEN)) begin
            r_text_mem[r_len[AW-1:0]] <= i_in.symbol;
        end
        r_t0 <= r_text_mem[txt_ra0];
        r_t1 <= r_text_mem[txt_ra1];
    end

    // Order memories, used alternately as merge source and destination.
    always_ff @(posedge i_clk) begin
        if (ord_we_a) begin
            r_ord_a[ord_wa] <= ord_wd;
        end
        r_a0 <= r_ord_a[ord_ra0];
        r_a1 <= r_ord_a[ord_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we_b) begin
            r_ord_b[ord_wa] <= ord_wd;
        end
        r_b0 <= r_ord_b[ord_ra0];
        r_b1 <= r_ord_b[ord_ra1];
    end

    // Sequencer, counters and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_CMP;
            r_sep       <= SEP_RESET;
            r_len       <= '0;
            r_seq       <= '0;
            r_built     <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sep <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out.bwt_symbol     <= '0;
                        r_out.rotation_start <= '0;
                        r_out.error          <= ERR_OK;
                        r_out.text_length    <= r_len;
                        r_out.sequence_count <= r_seq;
                        case (i_in.func)
                            FN_APPEND: begin
                                r_out_valid <= 1'b1;
                                if (r_len < CW'(MAX_LEN)) begin
                                    r_len             <= r_len + CW'(1);
                                    r_out.text_length <= r_len + CW'(1);
                                    r_built           <= 1'b0;
                                    if (i_in.symbol == r_sep) begin
                                        r_seq                <= r_seq + CW'(1);
                                        r_out.sequence_count <= r_seq + CW'(1);
                                    end
                                end else begin
                                    r_out.error <= ERR_FULL;
                                end
                            end
                            FN_BUILD: begin
                                r_sel <= 1'b0;
                                r_x   <= '0;
                                if (r_len == '0) begin
                                    r_built     <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_INIT;
                                end
                            end
                            FN_QUERY: begin
                                if (!r_built || CW'(i_in.rank) >= r_len) begin
                                    r_out.error <= ERR_QUERY;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_QRY_RD;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_QRY_RD: begin
                    // Clamp a stale start and point at the preceding symbol.
                    if (CW'(src0) >= r_len || src0 == '0) begin
                        r_start <= '0;
                        r_pa    <= n_len_m1[AW-1:0];
                    end else begin
                        r_start <= src0;
                        r_pa    <= src0 - AW'(1);
                    end
                    r_state <= S_QRY_TXT;
                end
                S_QRY_TXT: begin
                    r_state <= S_QRY_OUT;
                end
                S_QRY_OUT: begin
                    r_out.bwt_symbol     <= r_t0;
                    r_out.rotation_start <= r_start;
                    r_out_valid          <= 1'b1;
                    r_state              <= S_IDLE;
                end
                S_INIT: begin
                    r_x <= r_x + CW'(1);
                    if (r_x + CW'(1) == r_len) begin
                        r_width <= 12'd1;
                        r_lo    <= '0;
                        if (r_len == CW'(1)) begin
                            r_built     <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_SEG;
                        end
                    end
                end
                S_SEG: begin
                    r_mid   <= CW'(mid_w);
                    r_hi    <= CW'(hi_w);
                    r_x     <= CW'(r_lo);
                    r_y     <= CW'(mid_w);
                    r_o     <= CW'(r_lo);
                    r_state <= S_MRD;
                end
                S_MRD: begin
                    if (r_x < r_mid && r_y < r_hi) begin
                        r_mode  <= M_CMP;
                        r_state <= S_MSEL;
                    end else if (r_x < r_mid) begin
                        r_mode  <= M_CPX;
                        r_state <= S_MSEL;
                    end else if (r_y < r_hi) begin
                        r_mode  <= M_CPY;
                        r_state <= S_MSEL;
                    end else if (lo_next < 12'(r_len)) begin
                        r_lo    <= lo_next;
                        r_state <= S_SEG;
                    end else begin
                        // Pass done: swap source and destination.
                        r_sel   <= !r_sel;
                        r_width <= width_next;
                        r_lo    <= '0;
                        if (width_next < 12'(r_len)) begin
                            r_state <= S_SEG;
                        end else begin
                            r_built     <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_MSEL: begin
                    case (r_mode)
                        M_CPX: begin
                            r_x     <= r_x + CW'(1);
                            r_o     <= r_o + CW'(1);
                            r_state <= S_MRD;
                        end
                        M_CPY: begin
                            r_y     <= r_y + CW'(1);
                            r_o     <= r_o + CW'(1);
                            r_state <= S_MRD;
                        end
                        default: begin
                            r_ay    <= src1;
                            r_ax    <= src0;
                            r_pa    <= src1;
                            r_pb    <= src0;
                            r_k     <= '0;
                            r_state <= S_CRD;
                        end
                    endcase
                end
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                S_CCHK: begin
                    if (mrg_we) begin
                        if (less) begin
                            r_y <= r_y + CW'(1);
                        end else begin
                            r_x <= r_x + CW'(1);
                        end
                        r_o     <= r_o + CW'(1);
                        r_state <= S_MRD;
                    end else begin
                        r_pa    <= pa_inc[AW-1:0];
                        r_pb    <= pb_inc[AW-1:0];
                        r_k     <= r_k + CW'(1);
                        r_state <= S_CRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- bench/bwt_rotation_sort_core_tb.sv -----
// Self-checking testbench for the BWT rotation sorter: directed table, then random sessions.
module bwt_rotation_sort_core_tb;
    import bwt_pkg::*;

    localparam int NUM_ITEMS  = 1450;
    localparam int MAX_REPORT = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SW-1:0] i_cfg_wdata;
    logic i_in_valid;
    logic o_in_ready;
    t_in i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    bwt_rotation_sort_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out(o_out)
    );

    // Shadow state of the sorter.
    logic [SW-1:0] shadow_text [MAX_LEN];
    int            rank_to_start [MAX_LEN];
    int            merge_tmp [MAX_LEN];
    int            shadow_len;
    int            shadow_seps;
    bit            shadow_built;
    logic [SW-1:0] shadow_sep;

    // Pending results and run bookkeeping.
    t_out expected_results [$];
    int   sent_count;
    int   mismatch_count = 0;
    int   idle_pct;
    int   stall_pct;

    // Directed table row: a transaction and, where obvious, its result.
    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;

    t_row directed_rows [$];

    // Clock with a period of 10.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Symbol of the reversed text at position p.
    function automatic logic [SW-1:0] rev_symbol(int p, int n);
        return shadow_text[n - 1 - p];
    endfunction

    // True when the rotation starting at a sorts ahead of the one starting at b.
    function automatic bit rotation_ahead(int a, int b, int n);
        int pa;
        int pb;
        pa = a;
        pb = b;
        for (int k = 0; k < n; k++) begin
            if (rev_symbol(pa, n) != rev_symbol(pb, n))
                return rev_symbol(pa, n) < rev_symbol(pb, n);
            pa = (pa + 1 == n) ? 0 : pa + 1;
            pb = (pb + 1 == n) ? 0 : pb + 1;
        end
        return a < b;
    endfunction

    // Bottom-up merge sort of all rotation starts.
    function automatic void sort_rotations(int n);
        int lo;
        int mid;
        int hi;
        int x;
        int y;
        int o;
        for (int i = 0; i < n; i++)
            rank_to_start[i] = i;
        for (int w = 1; w < n; w *= 2) begin
            for (lo = 0; lo < n; lo += 2 * w) begin
                mid = (lo + w < n) ? lo + w : n;
                hi  = (mid + w < n) ? mid + w : n;
                x = lo;
                y = mid;
                o = lo;
                while (x < mid && y < hi) begin
                    if (rotation_ahead(rank_to_start[y], rank_to_start[x], n))
                        merge_tmp[o++] = rank_to_start[y++];
                    else
                        merge_tmp[o++] = rank_to_start[x++];
                end
                while (x < mid) merge_tmp[o++] = rank_to_start[x++];
                while (y < hi) merge_tmp[o++] = rank_to_start[y++];
            end
            for (int i = 0; i < n; i++)
                rank_to_start[i] = merge_tmp[i];
        end
    endfunction

    // Work out the result of one transaction and advance the shadow state.
    function automatic t_out predict_result(t_in x);
        t_out r;
        int p;
        r = '0;
        r.error = ERR_OK;
        case (x.func)
            FN_APPEND: begin
                if (shadow_len >= MAX_LEN) begin
                    r.error = ERR_FULL;
                end else begin
                    shadow_text[shadow_len] = x.symbol;
                    shadow_len++;
                    if (x.symbol == shadow_sep)
                        shadow_seps++;
                    shadow_built = 1'b0;
                end
            end
            FN_BUILD: begin
                sort_rotations(shadow_len);
                shadow_built = 1'b1;
            end
            FN_QUERY: begin
                if (!shadow_built || int'(x.rank) >= shadow_len) begin
                    r.error = ERR_QUERY;
                end else begin
                    p = rank_to_start[x.rank];
                    r.rotation_start = p[9:0];
                    r.bwt_symbol = rev_symbol((p == 0) ? shadow_len - 1 : p - 1, shadow_len);
                end
            end
            default: ;
        endcase
        r.text_length = shadow_len[10:0];
        r.sequence_count = shadow_seps[10:0];
        return r;
    endfunction

    function automatic t_out status_only(int len, int seps, logic [1:0] err);
        t_out r;
        r = '0;
        r.text_length = len[10:0];
        r.sequence_count = seps[10:0];
        r.error = err;
        return r;
    endfunction

    function automatic t_in make_item(logic [1:0] f, int sym, int rank);
        t_in x;
        x.func = f;
        x.symbol = sym[SW-1:0];
        x.rank = rank[9:0];
        return x;
    endfunction

    // Offer one transaction with random idle cycles ahead of it.
    task automatic send_item(t_in x, bit typed, t_out want);
        t_out predicted;
        case ((sent_count / 100) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 76; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 76; end
            default: begin idle_pct = 13; stall_pct = 13; end
        endcase
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in = x;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_result(x);
        if (typed)
            predicted = want;
        expected_results.insert(expected_results.size(), predicted);
        sent_count++;
    endtask

    task automatic send_op(logic [1:0] f, int sym, int rank);
        send_item(make_item(f, sym, rank), 1'b0, '0);
    endtask

    // Hold the sender off until every pending result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_separator(logic [SW-1:0] v);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        shadow_sep = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic int pick_symbol();
        int r;
        r = $urandom_range(99);
        if (r < 10) return int'(shadow_sep);
        if (r < 25) return $urandom_range(3);
        return $urandom_range(131071);
    endfunction

    function automatic int pick_rank();
        if (shadow_len > 0 && $urandom_range(99) < 85)
            return $urandom_range(shadow_len - 1);
        return $urandom_range(1023);
    endfunction

    task automatic add_row(logic [1:0] f, int sym, int rank, bit typed, t_out want);
        t_row row;
        row.item = make_item(f, sym, rank);
        row.typed = typed;
        row.want = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Result checker: each result against the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("Unexpected result transaction: %p", o_out);
            end else begin
                want = expected_results.pop_front();
                if (o_out.bwt_symbol !== want.bwt_symbol
                        || o_out.rotation_start !== want.rotation_start
                        || o_out.text_length !== want.text_length
                        || o_out.sequence_count !== want.sequence_count
                        || o_out.error !== want.error) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("Mismatch: expected %p, actual %p", want, o_out);
                end
            end
        end
    end

    // Receiver stalls.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog.
    initial begin
        #100000000;
        $display("Verification failed");
        $finish;
    end

    // Main stimulus.
    initial begin
        int burst;
        int queries;
        int session;
        int cfg_step;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in = '0;
        idle_pct = 0;
        stall_pct = 0;
        sent_count = 0;
        shadow_len = 0;
        shadow_seps = 0;
        shadow_built = 1'b0;
        shadow_sep = SEP_RESET;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty store, unused selector, loads of extremes, then a periodic text with ties.
        add_row(FN_QUERY, 0, 0, 1'b1, status_only(0, 0, ERR_QUERY));
        add_row(2'd3, 131071, 1023, 1'b1, status_only(0, 0, ERR_OK));
        add_row(FN_BUILD, 0, 0, 1'b1, status_only(0, 0, ERR_OK));
        add_row(FN_QUERY, 0, 0, 1'b1, status_only(0, 0, ERR_QUERY));
        add_row(FN_APPEND, 99999, 0, 1'b1, status_only(1, 1, ERR_OK));
        add_row(FN_APPEND, 0, 0, 1'b1, status_only(2, 1, ERR_OK));
        add_row(FN_APPEND, 131071, 1023, 1'b1, status_only(3, 1, ERR_OK));
        add_row(FN_QUERY, 0, 0, 1'b1, status_only(3, 1, ERR_QUERY));
        add_row(FN_BUILD, 0, 0, 1'b1, status_only(3, 1, ERR_OK));
        add_row(FN_QUERY, 0, 0, 1'b0, '0);
        add_row(FN_QUERY, 0, 1, 1'b0, '0);
        add_row(FN_QUERY, 0, 2, 1'b0, '0);
        add_row(FN_QUERY, 0, 3, 1'b1, status_only(3, 1, ERR_QUERY));
        add_row(FN_QUERY, 0, 1023, 1'b1, status_only(3, 1, ERR_QUERY));
        add_row(FN_APPEND, 99999, 0, 1'b1, status_only(4, 2, ERR_OK));
        add_row(FN_APPEND, 0, 0, 1'b1, status_only(5, 2, ERR_OK));
        add_row(FN_APPEND, 131071, 0, 1'b1, status_only(6, 2, ERR_OK));
        add_row(FN_QUERY, 0, 0, 1'b1, status_only(6, 2, ERR_QUERY));
        add_row(FN_BUILD, 0, 0, 1'b1, status_only(6, 2, ERR_OK));
        add_row(FN_BUILD, 0, 0, 1'b1, status_only(6, 2, ERR_OK));
        for (int r = 0; r < 6; r++)
            add_row(FN_QUERY, 0, r, 1'b0, '0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // Random sessions: a load burst, usually a build, then queries.
        session = 0;
        cfg_step = 0;
        while (sent_count < NUM_ITEMS - 10) begin
            if (session % 8 == 7) begin
                case (cfg_step % 4)
                    0: write_separator('0);
                    1: write_separator(17'h1FFFF);
                    2: write_separator($urandom_range(131071));
                    default: write_separator(SEP_RESET);
                endcase
                cfg_step++;
            end
            burst = $urandom_range(10, 60);
            if (sent_count > 1250 && shadow_len < MAX_LEN)
                burst = MAX_LEN - shadow_len + 3;
            repeat (burst) send_op(FN_APPEND, pick_symbol(), $urandom_range(1023));
            if ($urandom_range(99) < 5)
                send_op(2'd3, $urandom_range(131071), $urandom_range(1023));
            if ($urandom_range(99) < 75)
                send_op(FN_BUILD, $urandom_range(131071), $urandom_range(1023));
            queries = $urandom_range(3, 20);
            repeat (queries) send_op(FN_QUERY, $urandom_range(131071), pick_rank());
            session++;
        end

        // Full store: build and read both ends of the order.
        send_op(FN_BUILD, 0, 0);
        send_op(FN_QUERY, 0, 0);
        send_op(FN_QUERY, 0, 1023);
        send_op(FN_QUERY, 0, shadow_len > 0 ? shadow_len - 1 : 0);
        send_op(FN_APPEND, 131071, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bwt_pkg.sv
hw/rtl/bwt_rotation_sort_core.sv
bench/bwt_rotation_sort_core_tb.sv
